// ----- rtl/sqh_pkg.sv -----
// Shared constants and helpers for the square-to-quad homography core.
package sqh_pkg;

    localparam int COORD_FRAC_BITS = 14;
    localparam int COEF_FRAC_BITS  = 20;

    localparam int CW     = 16;   // corner coordinate width
    localparam int PW     = 17;   // corner operand width for the second products
    localparam int EW     = 18;   // edge vector width
    localparam int MW     = 36;   // edge product width
    localparam int BW     = 37;   // base, pg, ph width
    localparam int LOW_W  = 17;   // low slice of a split operand
    localparam int HIW    = BW - LOW_W;
    localparam int PHW    = PW + HIW;
    localparam int PLW    = PW + LOW_W + 1;
    localparam int DDW    = 40;   // signed common denominator width
    localparam int NUMW   = 56;   // numerator width
    localparam int DW     = 40;   // divisor magnitude width
    localparam int QW     = 32;   // quotient and coefficient width
    localparam int NW     = NUMW + COEF_FRAC_BITS;
    localparam int NLANE  = 8;
    localparam int NPROD  = 10;
    localparam int NDSTG  = QW + 1;      // divider init stage plus one stage per bit
    localparam int NSTG   = 8 + NDSTG + 1;

    // Fraction shift applied to each numerator before the divide.
    function automatic int lane_shift(input int lane);
        begin
            lane_shift = (lane < 6) ? (COEF_FRAC_BITS - COORD_FRAC_BITS) : COEF_FRAC_BITS;
        end
    endfunction

endpackage

// ----- rtl/square_to_quad_homography_core.sv -----
// Throughput: one item per cycle; the whole pipeline stalls together on output back-pressure.
// The pipeline holds the eight lanes of the restoring divider, one quotient bit per stage,
// behind eight stages of edge products, split multiplies and numerator sums.
// Reset (synchronous, active low) clears the valid bit of every stage; data is not cleared.
// Top level: square-to-quad homography coefficient pipeline.
module square_to_quad_homography_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [sqh_pkg::CW-1:0] i_corner0_x,
    input  logic signed [sqh_pkg::CW-1:0] i_corner0_y,
    input  logic signed [sqh_pkg::CW-1:0] i_corner1_x,
    input  logic signed [sqh_pkg::CW-1:0] i_corner1_y,
    input  logic signed [sqh_pkg::CW-1:0] i_corner2_x,
    input  logic signed [sqh_pkg::CW-1:0] i_corner2_y,
    input  logic signed [sqh_pkg::CW-1:0] i_corner3_x,
    input  logic signed [sqh_pkg::CW-1:0] i_corner3_y,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [sqh_pkg::QW-1:0] o_coef_a,
    output logic signed [sqh_pkg::QW-1:0] o_coef_b,
    output logic signed [sqh_pkg::QW-1:0] o_coef_c,
    output logic signed [sqh_pkg::QW-1:0] o_coef_d,
    output logic signed [sqh_pkg::QW-1:0] o_coef_e,
    output logic signed [sqh_pkg::QW-1:0] o_coef_f,
    output logic signed [sqh_pkg::QW-1:0] o_coef_g,
    output logic signed [sqh_pkg::QW-1:0] o_coef_h,
    output logic                        o_degenerate,
    output logic                        o_saturated
);
    import sqh_pkg::*;

    logic en;
    logic [NSTG-1:0] r_vld;

    // Stage 1: edge vectors and operand corners.
    logic signed [EW-1:0] r1_ex1, r1_ex2, r1_ex3, r1_ey1, r1_ey2, r1_ey3;
    logic signed [PW-1:0] r1_pt [NPROD];
    // Stage 2: edge products.
    logic signed [MW-1:0] r2_m [6];
    logic signed [PW-1:0] r2_pt [NPROD];
    // Stage 3: base, pg, ph.
    logic signed [BW-1:0] r3_base, r3_pg, r3_ph;
    logic signed [PW-1:0] r3_pt [NPROD];
    // Stage 4: split partial products.
    logic signed [BW-1:0]  n4_opb [NPROD];
    logic signed [PHW-1:0] r4_pp_hi [NPROD];
    logic signed [PLW-1:0] r4_pp_lo [NPROD];
    logic signed [DDW-1:0] r4_dd;
    logic signed [BW-1:0]  r4_pg, r4_ph;
    // Stage 5: full products.
    logic signed [NUMW-1:0] r5_prod [NPROD];
    logic signed [DDW-1:0]  r5_dd;
    logic signed [BW-1:0]   r5_pg, r5_ph;
    // Stage 6: pa, pb, pd, pe.
    logic signed [NUMW-1:0] r6_pa, r6_pb, r6_pd, r6_pe, r6_xb, r6_yb;
    logic signed [DDW-1:0]  r6_dd;
    logic signed [BW-1:0]   r6_pg, r6_ph;
    // Stage 7: numerators.
    logic signed [NUMW-1:0] r7_num [NLANE];
    logic signed [DDW-1:0]  r7_dd;
    // Stage 8: magnitudes and signs.
    logic [NUMW-1:0]  r8_mag [NLANE];
    logic [NLANE-1:0] r8_neg;
    logic [DW-1:0]    r8_d;
    logic             r8_degen;
    // Divider stages.
    logic [DW-1:0]    r_dv_rem [NDSTG][NLANE];
    logic [QW-1:0]    r_dv_low [NDSTG][NLANE];
    logic [QW-1:0]    r_dv_q   [NDSTG][NLANE];
    logic [NLANE-1:0] r_dv_ovf [NDSTG];
    logic [NLANE-1:0] r_dv_neg [NDSTG];
    logic [DW-1:0]    r_dv_d   [NDSTG];
    logic             r_dv_degen [NDSTG];
    logic [DW-1:0]    n_dv_rem [NDSTG][NLANE];
    logic [QW-1:0]    n_dv_low [NDSTG][NLANE];
    logic [QW-1:0]    n_dv_q   [NDSTG][NLANE];
    logic [NLANE-1:0] n_dv_ovf [NDSTG];
    // Output register.
    logic [QW-1:0]    r_out_coef [NLANE];
    logic             r_out_degen, r_out_sat;
    logic [QW-1:0]    n_out_coef [NLANE];
    logic             n_out_sat;

    assign en      = !r_vld[NSTG-1] || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    // Second-product operand b: base, pg or ph by product slot.
    always_comb begin
        for (int i = 0; i < NPROD; i++) begin
            if (i == 1 || i == 5) begin
                n4_opb[i] = r3_pg;
            end else if (i == 3 || i == 7) begin
                n4_opb[i] = r3_ph;
            end else begin
                n4_opb[i] = r3_base;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // Stage 1
            r1_ex1 <= EW'(i_corner1_x) - EW'(i_corner2_x);
            r1_ex2 <= EW'(i_corner3_x) - EW'(i_corner2_x);
            r1_ex3 <= EW'(i_corner0_x) - EW'(i_corner1_x) + EW'(i_corner2_x)
                      - EW'(i_corner3_x);
            r1_ey1 <= EW'(i_corner1_y) - EW'(i_corner2_y);
            r1_ey2 <= EW'(i_corner3_y) - EW'(i_corner2_y);
            r1_ey3 <= EW'(i_corner0_y) - EW'(i_corner1_y) + EW'(i_corner2_y)
                      - EW'(i_corner3_y);
            r1_pt[0] <= PW'(i_corner1_x) - PW'(i_corner0_x);
            r1_pt[1] <= PW'(i_corner1_x);
            r1_pt[2] <= PW'(i_corner3_x) - PW'(i_corner0_x);
            r1_pt[3] <= PW'(i_corner3_x);
            r1_pt[4] <= PW'(i_corner1_y) - PW'(i_corner0_y);
            r1_pt[5] <= PW'(i_corner1_y);
            r1_pt[6] <= PW'(i_corner3_y) - PW'(i_corner0_y);
            r1_pt[7] <= PW'(i_corner3_y);
            r1_pt[8] <= PW'(i_corner0_x);
            r1_pt[9] <= PW'(i_corner0_y);
            // Stage 2
            r2_m[0] <= r1_ex1 * r1_ey2;
            r2_m[1] <= r1_ex2 * r1_ey1;
            r2_m[2] <= r1_ex3 * r1_ey2;
            r2_m[3] <= r1_ex2 * r1_ey3;
            r2_m[4] <= r1_ex1 * r1_ey3;
            r2_m[5] <= r1_ex3 * r1_ey1;
            r2_pt   <= r1_pt;
            // Stage 3
            r3_base <= BW'(r2_m[0]) - BW'(r2_m[1]);
            r3_pg   <= BW'(r2_m[2]) - BW'(r2_m[3]);
            r3_ph   <= BW'(r2_m[4]) - BW'(r2_m[5]);
            r3_pt   <= r2_pt;
            // Stage 4: the wide operand is split into a signed high and an unsigned low slice.
            for (int i = 0; i < NPROD; i++) begin
                r4_pp_hi[i] <= r3_pt[i] * $signed(n4_opb[i][BW-1:LOW_W]);
                r4_pp_lo[i] <= r3_pt[i] * $signed({1'b0, n4_opb[i][LOW_W-1:0]});
            end
            r4_dd <= (DDW'(r3_base) <<< 1) + DDW'(r3_pg) + DDW'(r3_ph);
            r4_pg <= r3_pg;
            r4_ph <= r3_ph;
            // Stage 5
            for (int i = 0; i < NPROD; i++) begin
                r5_prod[i] <= (NUMW'(r4_pp_hi[i]) <<< LOW_W) + NUMW'(r4_pp_lo[i]);
            end
            r5_dd <= r4_dd;
            r5_pg <= r4_pg;
            r5_ph <= r4_ph;
            // Stage 6
            r6_pa <= r5_prod[0] + r5_prod[1];
            r6_pb <= r5_prod[2] + r5_prod[3];
            r6_pd <= r5_prod[4] + r5_prod[5];
            r6_pe <= r5_prod[6] + r5_prod[7];
            r6_xb <= r5_prod[8];
            r6_yb <= r5_prod[9];
            r6_dd <= r5_dd;
            r6_pg <= r5_pg;
            r6_ph <= r5_ph;
            // Stage 7
            r7_num[0] <= r6_pa <<< 1;
            r7_num[1] <= r6_pb <<< 1;
            r7_num[2] <= (r6_xb <<< 1) + r6_pa + r6_pb;
            r7_num[3] <= r6_pd <<< 1;
            r7_num[4] <= r6_pe <<< 1;
            r7_num[5] <= (r6_yb <<< 1) + r6_pd + r6_pe;
            r7_num[6] <= NUMW'(r6_pg) <<< 1;
            r7_num[7] <= NUMW'(r6_ph) <<< 1;
            r7_dd     <= r6_dd;
            // Stage 8
            for (int l = 0; l < NLANE; l++) begin
                r8_mag[l] <= r7_num[l][NUMW-1] ? NUMW'(-r7_num[l]) : NUMW'(r7_num[l]);
                r8_neg[l] <= r7_num[l][NUMW-1] ^ r7_dd[DDW-1];
            end
            r8_d     <= r7_dd[DDW-1] ? DW'(-r7_dd) : DW'(r7_dd);
            r8_degen <= (r7_dd == '0);
        end
    end

    // Divider: the init stage checks for a quotient of 2^QW or more, then one bit per stage.
    always_comb begin
        logic [NW-1:0]    nv;
        logic [NW-QW-1:0] top;
        logic [DW:0]      t;
        logic             ge;
        for (int l = 0; l < NLANE; l++) begin
            nv  = NW'(r8_mag[l]) << lane_shift(l);
            top = nv[NW-1:QW];
            n_dv_ovf[0][l] = (top >= (NW-QW)'(r8_d));
            n_dv_rem[0][l] = top[DW-1:0];
            n_dv_low[0][l] = nv[QW-1:0];
            n_dv_q[0][l]   = '0;
        end
        for (int k = 1; k < NDSTG; k++) begin
            for (int l = 0; l < NLANE; l++) begin
                t  = {r_dv_rem[k-1][l], r_dv_low[k-1][l][QW-1]};
                ge = (t >= {1'b0, r_dv_d[k-1]});
                n_dv_rem[k][l] = ge ? DW'(t - {1'b0, r_dv_d[k-1]}) : DW'(t);
                n_dv_low[k][l] = {r_dv_low[k-1][l][QW-2:0], 1'b0};
                n_dv_q[k][l]   = {r_dv_q[k-1][l][QW-2:0], ge};
            end
            n_dv_ovf[k] = r_dv_ovf[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_rem   <= n_dv_rem;
            r_dv_low   <= n_dv_low;
            r_dv_q     <= n_dv_q;
            r_dv_ovf   <= n_dv_ovf;
            r_dv_neg[0]   <= r8_neg;
            r_dv_d[0]     <= r8_d;
            r_dv_degen[0] <= r8_degen;
            for (int k = 1; k < NDSTG; k++) begin
                r_dv_neg[k]   <= r_dv_neg[k-1];
                r_dv_d[k]     <= r_dv_d[k-1];
                r_dv_degen[k] <= r_dv_degen[k-1];
            end
        end
    end

    // Round half away from zero on the magnitude, then clip to the signed range; a degenerate item gives zeros.
    always_comb begin
        logic [QW:0] qr;
        logic [QW:0] lim;
        logic [QW:0] mag;
        logic        up;
        logic        sat;
        n_out_sat = 1'b0;
        for (int l = 0; l < NLANE; l++) begin
            up  = ({r_dv_rem[NDSTG-1][l], 1'b0} >= {1'b0, r_dv_d[NDSTG-1]});
            qr  = {1'b0, r_dv_q[NDSTG-1][l]} + (QW+1)'(up);
            lim = r_dv_neg[NDSTG-1][l] ? (QW+1)'(1) << (QW-1)
                                       : ((QW+1)'(1) << (QW-1)) - (QW+1)'(1);
            sat = r_dv_ovf[NDSTG-1][l] || (qr > lim);
            mag = sat ? lim : qr;
            if (r_dv_degen[NDSTG-1]) begin
                n_out_coef[l] = '0;
            end else begin
                n_out_coef[l] = r_dv_neg[NDSTG-1][l] ? QW'(-mag) : QW'(mag);
                n_out_sat     = n_out_sat | sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_coef  <= n_out_coef;
            r_out_sat   <= n_out_sat;
            r_out_degen <= r_dv_degen[NDSTG-1];
        end
    end

    assign o_valid      = r_vld[NSTG-1];
    assign o_coef_a     = r_out_coef[0];
    assign o_coef_b     = r_out_coef[1];
    assign o_coef_c     = r_out_coef[2];
    assign o_coef_d     = r_out_coef[3];
    assign o_coef_e     = r_out_coef[4];
    assign o_coef_f     = r_out_coef[5];
    assign o_coef_g     = r_out_coef[6];
    assign o_coef_h     = r_out_coef[7];
    assign o_degenerate = r_out_degen;
    assign o_saturated  = r_out_sat;

endmodule
